// File: src/prqs_pkg.sv
// Shared constants, request and error codes for the ready-queue scheduler.
package prqs_pkg;

    localparam int QUEUE_DEPTH_DEF  = 16;
    localparam int ID_BITS_DEF      = 8;
    localparam int PRIO_BITS_DEF    = 6;

    localparam int REQ_W    = 3;
    localparam int ID_W     = 8;
    localparam int PRIO_W   = 6;
    localparam int SLICE_W  = 8;
    localparam int ERR_W    = 2;
    localparam int COUNT_W  = 5;

    localparam logic [SLICE_W-1:0] SLICE_LEN_RESET  = 8'd4;
    localparam logic [SLICE_W-1:0] SLICE_MAX        = 8'hFF;

    typedef enum logic [REQ_W-1:0] {
        REQ_TICK    = 3'd0,
        REQ_CREATE  = 3'd1,
        REQ_UNBLOCK = 3'd2,
        REQ_YIELD   = 3'd3,
        REQ_BLOCK   = 3'd4,
        REQ_EXIT    = 3'd5,
        REQ_SETPRI  = 3'd6
    } t_req;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK      = 2'd0,
        ERR_FULL    = 2'd1,
        ERR_NO_TASK = 2'd2
    } t_err;

endpackage

// File: src/prqs_queue.sv
// Ready-queue storage: one write port and one registered read port.
module prqs_queue #(
    parameter int QUEUE_DEPTH = prqs_pkg::QUEUE_DEPTH_DEF,
    parameter int ENTRY_BITS  = prqs_pkg::ID_BITS_DEF + prqs_pkg::PRIO_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_wr_en,
    input  logic [$clog2(QUEUE_DEPTH)-1:0] i_wr_addr,
    input  logic [ENTRY_BITS-1:0]          i_wr_data,
    input  logic [$clog2(QUEUE_DEPTH)-1:0] i_rd_addr,
    output logic [ENTRY_BITS-1:0]          o_rd_data
);

    logic [ENTRY_BITS-1:0] r_mem [QUEUE_DEPTH];
    logic [ENTRY_BITS-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: src/priority_ready_queue_scheduler.sv
// Ready-queue scheduler top level: event sequencer, running-task state and output stage.
// Each beat on the request channel is one scheduling event and yields exactly one result
// beat. A tick, an event that fails with an error, an unknown request, a yield with nothing
// to take and a block or exit into an empty queue go from acceptance straight to the result
// stage. Events that touch the ready queue use a queue memory with one write port and one
// registered read port, moving one entry per read state and the state after it. An ordered
// insert reads from the tail and moves each lower-priority entry back one slot; taking the
// head reads it and shifts each remaining entry forward one slot. A yield or set priority
// that swaps the running task takes the head, then inserts the old task; a preempting
// create inserts, then swaps with the head. The request channel is ready whenever the
// sequencer is idle; one finished result may wait in the output register while the next
// event runs. The slice-length register is always ready and takes effect on the next tick;
// write it only while no event is in flight.
module priority_ready_queue_scheduler #(
    parameter int QUEUE_DEPTH = prqs_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = prqs_pkg::ID_BITS_DEF,
    parameter int PRIO_BITS   = prqs_pkg::PRIO_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [prqs_pkg::SLICE_W-1:0]   i_cfg_slice_len,
    // request channel
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [prqs_pkg::REQ_W-1:0]     i_req_type,
    input  logic [prqs_pkg::ID_W-1:0]      i_task_id,
    input  logic [prqs_pkg::PRIO_W-1:0]    i_task_priority,
    // result channel
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [prqs_pkg::ID_W-1:0]      o_running_id,
    output logic                           o_running_idle,
    output logic                           o_switched,
    output logic                           o_slice_expired,
    output logic [prqs_pkg::ERR_W-1:0]     o_error_code,
    output logic [prqs_pkg::COUNT_W-1:0]   o_ready_count
);

    localparam int IW = (ID_BITS < prqs_pkg::ID_W) ? ID_BITS : prqs_pkg::ID_W;
    localparam int PW = (PRIO_BITS < prqs_pkg::PRIO_W) ? PRIO_BITS : prqs_pkg::PRIO_W;
    localparam int EW = IW + PW;
    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_HD_RD  = 8'b0000_0010,
        S_HD_CHK = 8'b0000_0100,
        S_SH_RD  = 8'b0000_1000,
        S_SH_WR  = 8'b0001_0000,
        S_IN_RD  = 8'b0010_0000,
        S_IN_CMP = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } t_state;

    // control state
    t_state                        r_state,      n_state;
    logic [prqs_pkg::SLICE_W-1:0]  r_slice_len,  n_slice_len;
    logic [CW-1:0]                 r_fill,       n_fill;
    logic [IW-1:0]                 r_cur_id,     n_cur_id;
    logic [PW-1:0]                 r_cur_prio,   n_cur_prio;
    logic                          r_idle,       n_idle;
    logic [prqs_pkg::SLICE_W-1:0]  r_slice,      n_slice;
    logic                          r_o_valid,    n_o_valid;

    // per-event working registers
    logic [CW-1:0]                 r_idx,        n_idx;
    logic [IW-1:0]                 r_new_id,     n_new_id;
    logic [PW-1:0]                 r_new_prio,   n_new_prio;
    logic                          r_yield,      n_yield;
    logic                          r_strict,     n_strict;
    logic                          r_drop,       n_drop;
    logic                          r_ins_old,    n_ins_old;
    logic                          r_sw,         n_sw;
    logic                          r_exp,        n_exp;
    prqs_pkg::t_err                r_err,        n_err;

    // result register
    logic [prqs_pkg::ID_W-1:0]     r_o_id,       n_o_id;
    logic                          r_o_idle,     n_o_idle;
    logic                          r_o_sw,       n_o_sw;
    logic                          r_o_exp,      n_o_exp;
    logic [prqs_pkg::ERR_W-1:0]    r_o_err,      n_o_err;
    logic [prqs_pkg::COUNT_W-1:0]  r_o_count,    n_o_count;

    // queue memory port
    logic                          q_wr_en;
    logic [AW-1:0]                 q_wr_addr;
    logic [EW-1:0]                 q_wr_data;
    logic [AW-1:0]                 q_rd_addr;
    logic [EW-1:0]                 q_rd_data;
    logic [IW-1:0]                 rd_id;
    logic [PW-1:0]                 rd_prio;

    logic [IW-1:0]                 in_id;
    logic [PW-1:0]                 in_prio;
    logic [PW-1:0]                 run_prio;
    logic [prqs_pkg::SLICE_W-1:0]  slice_inc;
    logic [CW-1:0]                 idx_m1;
    logic [CW-1:0]                 idx_p1;
    logic [CW-1:0]                 fill_m1;
    logic [CW-1:0]                 fill_p1;
    logic                          take;
    logic                          keep_old;
    logic                          acc;

    prqs_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ENTRY_BITS  (EW)
    ) u_queue (
        .i_clk     (i_clk),
        .i_wr_en   (q_wr_en),
        .i_wr_addr (q_wr_addr),
        .i_wr_data (q_wr_data),
        .i_rd_addr (q_rd_addr),
        .o_rd_data (q_rd_data)
    );

    assign rd_id     = q_rd_data[EW-1:PW];
    assign rd_prio   = q_rd_data[PW-1:0];
    assign in_id     = IW'(i_task_id);
    assign in_prio   = PW'(i_task_priority);
    assign run_prio  = r_idle ? '0 : r_cur_prio;
    assign slice_inc = (r_slice == prqs_pkg::SLICE_MAX) ? r_slice : r_slice + 8'd1;
    assign idx_m1    = r_idx - CW'(1);
    assign idx_p1    = r_idx + CW'(1);
    assign fill_m1   = r_fill - CW'(1);
    assign fill_p1   = r_fill + CW'(1);
    // setprio only switches to a strictly higher head; yields also rotate among equals
    assign take      = r_drop || r_idle || (r_strict ? (rd_prio > r_cur_prio)
                                                     : (rd_prio >= r_cur_prio));
    assign keep_old  = !r_idle && !r_drop;

    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign acc         = i_valid && o_ready;

    always_comb begin
        n_state      = r_state;
        n_slice_len  = i_cfg_valid ? i_cfg_slice_len : r_slice_len;
        n_fill       = r_fill;
        n_cur_id     = r_cur_id;
        n_cur_prio   = r_cur_prio;
        n_idle       = r_idle;
        n_slice      = r_slice;
        n_o_valid    = r_o_valid && !i_ready;
        n_idx        = r_idx;
        n_new_id     = r_new_id;
        n_new_prio   = r_new_prio;
        n_yield      = r_yield;
        n_strict     = r_strict;
        n_drop       = r_drop;
        n_ins_old    = r_ins_old;
        n_sw         = r_sw;
        n_exp        = r_exp;
        n_err        = r_err;
        n_o_id       = r_o_id;
        n_o_idle     = r_o_idle;
        n_o_sw       = r_o_sw;
        n_o_exp      = r_o_exp;
        n_o_err      = r_o_err;
        n_o_count    = r_o_count;
        q_wr_en      = 1'b0;
        q_wr_addr    = '0;
        q_wr_data    = {r_new_id, r_new_prio};
        q_rd_addr    = '0;

        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_sw       = 1'b0;
                    n_exp      = 1'b0;
                    n_err      = prqs_pkg::ERR_OK;
                    n_yield    = 1'b0;
                    n_strict   = 1'b0;
                    n_drop     = 1'b0;
                    n_ins_old  = 1'b0;
                    n_new_id   = in_id;
                    n_new_prio = in_prio;
                    n_state    = S_DONE;
                    case (i_req_type)
                        prqs_pkg::REQ_TICK: begin
                            n_slice = slice_inc;
                            n_exp   = (slice_inc >= r_slice_len);
                        end
                        prqs_pkg::REQ_CREATE, prqs_pkg::REQ_UNBLOCK: begin
                            if (r_fill == CW'(QUEUE_DEPTH)) begin
                                n_err = prqs_pkg::ERR_FULL;
                            end else begin
                                n_idx   = r_fill;
                                n_yield = (i_req_type == prqs_pkg::REQ_CREATE) &&
                                          (run_prio < in_prio);
                                n_state = S_IN_RD;
                            end
                        end
                        prqs_pkg::REQ_YIELD: begin
                            n_slice = '0;
                            if (r_fill != '0) begin
                                n_state = S_HD_RD;
                            end
                        end
                        prqs_pkg::REQ_BLOCK, prqs_pkg::REQ_EXIT: begin
                            if (r_idle) begin
                                n_err = prqs_pkg::ERR_NO_TASK;
                            end else begin
                                n_slice = '0;
                                n_sw    = 1'b1;
                                if (r_fill != '0) begin
                                    n_drop  = 1'b1;
                                    n_state = S_HD_RD;
                                end else begin
                                    n_idle     = 1'b1;
                                    n_cur_id   = '0;
                                    n_cur_prio = '0;
                                end
                            end
                        end
                        prqs_pkg::REQ_SETPRI: begin
                            if (r_idle) begin
                                n_err = prqs_pkg::ERR_NO_TASK;
                            end else begin
                                n_cur_prio = in_prio;
                                n_strict   = 1'b1;
                                if (r_fill != '0) begin
                                    n_state = S_HD_RD;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_HD_RD: begin
                q_rd_addr = '0;
                n_state   = S_HD_CHK;
            end
            S_HD_CHK: begin
                if (take) begin
                    n_cur_id   = rd_id;
                    n_cur_prio = rd_prio;
                    n_idle     = 1'b0;
                    n_sw       = 1'b1;
                    n_slice    = '0;
                    n_ins_old  = keep_old;
                    n_new_id   = r_cur_id;
                    n_new_prio = r_cur_prio;
                    n_fill     = fill_m1;
                    if (r_fill > CW'(1)) begin
                        n_idx   = CW'(1);
                        n_state = S_SH_RD;
                    end else if (keep_old) begin
                        n_idx   = fill_m1;
                        n_state = S_IN_RD;
                    end else begin
                        n_state = S_DONE;
                    end
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SH_RD: begin
                q_rd_addr = r_idx[AW-1:0];
                n_state   = S_SH_WR;
            end
            S_SH_WR: begin
                // r_fill already holds the shortened count here
                q_wr_en   = 1'b1;
                q_wr_addr = idx_m1[AW-1:0];
                q_wr_data = q_rd_data;
                if (r_idx >= r_fill) begin
                    if (r_ins_old) begin
                        n_idx   = r_fill;
                        n_state = S_IN_RD;
                    end else begin
                        n_state = S_DONE;
                    end
                end else begin
                    n_idx   = idx_p1;
                    n_state = S_SH_RD;
                end
            end
            S_IN_RD: begin
                if (r_idx == '0) begin
                    q_wr_en   = 1'b1;
                    q_wr_addr = '0;
                    n_fill    = fill_p1;
                    n_yield   = 1'b0;
                    n_state   = r_yield ? S_HD_RD : S_DONE;
                end else begin
                    q_rd_addr = idx_m1[AW-1:0];
                    n_state   = S_IN_CMP;
                end
            end
            S_IN_CMP: begin
                q_wr_en   = 1'b1;
                q_wr_addr = r_idx[AW-1:0];
                if (rd_prio >= r_new_prio) begin
                    n_fill  = fill_p1;
                    n_yield = 1'b0;
                    n_state = r_yield ? S_HD_RD : S_DONE;
                end else begin
                    // lower priority entry moves one slot toward the tail
                    q_wr_data = q_rd_data;
                    n_idx     = idx_m1;
                    n_state   = S_IN_RD;
                end
            end
            S_DONE: begin
                if (!r_o_valid || i_ready) begin
                    n_o_valid = 1'b1;
                    n_o_id    = r_idle ? '0 : prqs_pkg::ID_W'(r_cur_id);
                    n_o_idle  = r_idle;
                    n_o_sw    = r_sw;
                    n_o_exp   = r_exp;
                    n_o_err   = r_err;
                    n_o_count = prqs_pkg::COUNT_W'(r_fill);
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_slice_len  <= prqs_pkg::SLICE_LEN_RESET;
            r_fill       <= '0;
            r_cur_id     <= '0;
            r_cur_prio   <= '0;
            r_idle       <= 1'b1;
            r_slice      <= '0;
            r_o_valid    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_slice_len  <= n_slice_len;
            r_fill       <= n_fill;
            r_cur_id     <= n_cur_id;
            r_cur_prio   <= n_cur_prio;
            r_idle       <= n_idle;
            r_slice      <= n_slice;
            r_o_valid    <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_new_id   <= n_new_id;
        r_new_prio <= n_new_prio;
        r_yield    <= n_yield;
        r_strict   <= n_strict;
        r_drop     <= n_drop;
        r_ins_old  <= n_ins_old;
        r_sw       <= n_sw;
        r_exp      <= n_exp;
        r_err      <= n_err;
        r_o_id     <= n_o_id;
        r_o_idle   <= n_o_idle;
        r_o_sw     <= n_o_sw;
        r_o_exp    <= n_o_exp;
        r_o_err    <= n_o_err;
        r_o_count  <= n_o_count;
    end

    assign o_valid         = r_o_valid;
    assign o_running_id    = r_o_id;
    assign o_running_idle  = r_o_idle;
    assign o_switched      = r_o_sw;
    assign o_slice_expired = r_o_exp;
    assign o_error_code    = r_o_err;
    assign o_ready_count   = r_o_count;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(QUEUE_DEPTH))
        else $error("ready queue count above depth");

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idle |-> (r_cur_id == '0 && r_cur_prio == '0))
        else $error("idle with a stale current task");

    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_fill == $past(r_fill) || r_fill == $past(r_fill) + CW'(1) ||
                  r_fill == $past(r_fill) - CW'(1)))
        else $error("ready queue count jumped");

    a_head_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HD_RD) |-> (r_fill != '0))
        else $error("head read from an empty queue");

    a_tick_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_req_type == prqs_pkg::REQ_TICK) |=> (r_state == S_DONE))
        else $error("tick did not finish at once");

endmodule
